// ===== sv/vsts_pkg.sv =====
`timescale 1ns / 1ps

package vsts_pkg;

  localparam int DIM_BITS   = 5;
  localparam int VOXEL_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int POS_W    = DIM_BITS + FRAC_BITS;
  localparam int VALUE_W  = 16;
  localparam int CMD_W    = 2;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int RES_W    = 24;
  localparam int ADDR_W   = 3 * DIM_BITS;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int WGT_W    = FRAC_BITS + 1;

  localparam int IN_BITS   = 3 * POS_W + VALUE_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  // shared multiplier: weight product or plain weight times weight or voxel
  localparam int MA_W  = 3 * FRAC_BITS + 2;
  localparam int MB_W  = ((VOXEL_BITS > WGT_W) ? VOXEL_BITS : WGT_W) + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = P_W + 1;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(32);
  localparam logic [CFG_W-1:0] SIDE       = CFG_W'(1 << DIM_BITS);
  localparam logic [WGT_W-1:0] ONE_W      = WGT_W'(1 << FRAC_BITS);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_ACCUM  = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

endpackage

// ===== sv/voxel_store_trilinear_sampler_core.sv =====
`timescale 1ns / 1ps

// channel   direction  tdata (low bit up)                        tuser          tlast
// s_axis    in         x_pos[12:0] y_pos[25:13] z_pos[38:26]     cmd[1:0]       batch_end
//                      value[54:39], bit 55 unused
// m_axis    out        result_value[23:0]                        out_of_range   last
// cfg       in         cfg_we / cfg_index / cfg_data, no handshake
//
// write and out-of-range items: pass CHECK and DONE, then ready again
// read/accumulate: CHECK, RDW, DONE; one registered single-port read, accumulate writes in RDW
// sample: four steps per neighbor (W1, W2, W3, SUM) on the one multiplier and memory port
// result sits in an output register, so the next item runs while it waits
// a full output register holds the sequencer in its final step
// rst is synchronous; the voxel memory is not cleared and holds garbage until written

module voxel_store_trilinear_sampler_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [vsts_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // x_pos, y_pos, z_pos, value
  input  logic [vsts_pkg::CMD_W-1:0]        s_axis_tuser,  // cmd
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [vsts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // result_value
  output logic                              m_axis_tuser,  // out_of_range
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [vsts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vsts_pkg::CFG_W-1:0]        cfg_data
);

  import vsts_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_RDW   = 11'b00000000100,
    S_W1    = 11'b00000001000,
    S_W2    = 11'b00000010000,
    S_W3    = 11'b00000100000,
    S_SUM   = 11'b00001000000,
    S_ROUND = 11'b00010000000,
    S_DONE  = 11'b00100000000,
    S_SPARE0 = 11'b01000000000,
    S_SPARE1 = 11'b10000000000
  } state_t;

  typedef logic [DIM_BITS-1:0]  idx_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  state_t state, state_next;

  logic [CFG_W-1:0] size_x, size_y, size_z;

  cmd_t                       cmd_q;
  idx_t                       xi, yi, zi, xu, yu, zu;
  frac_t                      fx, fy, fz;
  logic signed [VALUE_W-1:0]  val_q;
  logic                       last_q;
  logic                       oor_q;
  logic [RES_W-1:0]           res_q;
  logic [2:0]                 n;
  logic signed [P_W-1:0]      prod;
  logic signed [ACC_W-1:0]    acc;

  logic [VOXEL_BITS-1:0]        mem [DEPTH];
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_addr;
  logic [VOXEL_BITS-1:0]        mem_wdata;
  logic signed [VOXEL_BITS-1:0] rd_q;

  logic                         oor;
  idx_t                         xu_c, yu_c, zu_c;
  logic [CFG_W-1:0]             lim_x, lim_y, lim_z;
  logic [WGT_W-1:0]             wx, wy, wz;
  logic signed [MA_W-1:0]       mul_a;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [P_W-1:0]        mul_p;
  logic signed [ACC_W-1:0]      rnd;
  logic [ADDR_W-1:0]            base_addr, nbr_addr;
  logic                         out_load;

  assign s_axis_tready = !rst && (state == S_IDLE);

  // range check and clamped upper neighbors
  always_comb begin
    lim_x = (size_x > SIDE) ? SIDE : size_x;
    lim_y = (size_y > SIDE) ? SIDE : size_y;
    lim_z = (size_z > SIDE) ? SIDE : size_z;
    xu_c = ((CFG_W'(xi) + CFG_W'(1)) < lim_x) ? idx_t'(xi + idx_t'(1)) : idx_t'(lim_x - 1'b1);
    yu_c = ((CFG_W'(yi) + CFG_W'(1)) < lim_y) ? idx_t'(yi + idx_t'(1)) : idx_t'(lim_y - 1'b1);
    zu_c = ((CFG_W'(zi) + CFG_W'(1)) < lim_z) ? idx_t'(zi + idx_t'(1)) : idx_t'(lim_z - 1'b1);
    oor = (CFG_W'(xi) >= size_x) || (CFG_W'(yi) >= size_y) || (CFG_W'(zi) >= size_z);
    if (cmd_q == CMD_SAMPLE) begin
      oor = oor ||
            ((CFG_W'(xi) + CFG_W'(1) == size_x) && (fx != '0)) ||
            ((CFG_W'(yi) + CFG_W'(1) == size_y) && (fy != '0)) ||
            ((CFG_W'(zi) + CFG_W'(1) == size_z) && (fz != '0));
    end
  end

  // neighbor n: x from bit 0, y from bit 1, z from bit 2
  always_comb begin
    wx = n[0] ? WGT_W'(fx) : WGT_W'(ONE_W - WGT_W'(fx));
    wy = n[1] ? WGT_W'(fy) : WGT_W'(ONE_W - WGT_W'(fy));
    wz = n[2] ? WGT_W'(fz) : WGT_W'(ONE_W - WGT_W'(fz));
    base_addr = {zi, yi, xi};
    nbr_addr  = {(n[2] ? zu : zi), (n[1] ? yu : yi), (n[0] ? xu : xi)};
  end

  // the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_W1: begin
        mul_a = MA_W'(wy);
        mul_b = MB_W'(wz);
      end
      S_W2: begin
        mul_a = MA_W'(prod);
        mul_b = MB_W'(wx);
      end
      S_W3: begin
        mul_a = MA_W'(prod);
        mul_b = MB_W'(rd_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
    rnd   = acc + (ACC_W'(1) << (2 * FRAC_BITS - 1));
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = base_addr;
    mem_wdata = VOXEL_BITS'(val_q);
    case (state)
      S_CHECK: begin
        mem_we = !oor && (cmd_q == CMD_WRITE);
      end
      S_RDW: begin
        mem_we    = (cmd_q == CMD_ACCUM);
        mem_wdata = VOXEL_BITS'(rd_q + VOXEL_BITS'(val_q));
      end
      S_W2: begin
        mem_addr = nbr_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (oor || cmd_q == CMD_WRITE) begin
          state_next = S_DONE;
        end else if (cmd_q == CMD_SAMPLE) begin
          state_next = S_W1;
        end else begin
          state_next = S_RDW;
        end
      end
      S_RDW:   state_next = S_DONE;
      S_W1:    state_next = S_W2;
      S_W2:    state_next = S_W3;
      S_W3:    state_next = S_SUM;
      S_SUM:   state_next = (n == 3'd7) ? S_ROUND : S_W1;
      S_ROUND: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      size_x        <= SIZE_RESET;
      size_y        <= SIZE_RESET;
      size_z        <= SIZE_RESET;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_X: size_x <= cfg_data;
          REG_SIZE_Y: size_y <= cfg_data;
          REG_SIZE_Z: size_z <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q  <= cmd_t'(s_axis_tuser);
            fx     <= s_axis_tdata[FRAC_BITS-1:0];
            xi     <= s_axis_tdata[POS_W-1:FRAC_BITS];
            fy     <= s_axis_tdata[POS_W+FRAC_BITS-1:POS_W];
            yi     <= s_axis_tdata[2*POS_W-1:POS_W+FRAC_BITS];
            fz     <= s_axis_tdata[2*POS_W+FRAC_BITS-1:2*POS_W];
            zi     <= s_axis_tdata[3*POS_W-1:2*POS_W+FRAC_BITS];
            val_q  <= s_axis_tdata[3*POS_W+VALUE_W-1:3*POS_W];
            last_q <= s_axis_tlast;
          end
        end
        S_CHECK: begin
          oor_q <= oor;
          xu    <= xu_c;
          yu    <= yu_c;
          zu    <= zu_c;
          res_q <= '0;
          n     <= '0;
          acc   <= '0;
        end
        S_RDW: begin
          res_q <= RES_W'($signed({rd_q, {FRAC_BITS{1'b0}}}));
        end
        S_W1, S_W2, S_W3: begin
          prod <= mul_p;
        end
        S_SUM: begin
          acc <= acc + ACC_W'(prod);
          n   <= n + 3'd1;
        end
        S_ROUND: begin
          res_q <= RES_W'(rnd >>> (2 * FRAC_BITS));
        end
        S_DONE: begin
          if (out_load) begin
            m_axis_tdata <= OUT_DATA_W'(res_q);
            m_axis_tuser <= oor_q;
            m_axis_tlast <= last_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
